[rtl/ray_triangle_nearest_hit_assert.svh]
// Assertion macros for the ray/triangle nearest-hit checker.
`ifndef RAY_TRIANGLE_NEAREST_HIT_ASSERT_SVH
`define RAY_TRIANGLE_NEAREST_HIT_ASSERT_SVH

// same-cycle implication
`define RTN_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ray_triangle_nearest_hit: check failed");

// next-cycle implication
`define RTN_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ray_triangle_nearest_hit: check failed");

`endif

[rtl/rtn_pkg.sv]
// Shared types, constants and the multiply-accumulate program of the nearest-hit block.
package rtn_pkg;

   localparam int COORD_WIDTH      = 32;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int DIFF_W           = COORD_WIDTH + 1;
   localparam int OPA_W            = 2 * COORD_WIDTH + 4;
   localparam int OPB_W            = COORD_WIDTH + 2;
   localparam int DIGIT_W          = 8;
   localparam int NDIG             = (OPB_W + DIGIT_W - 1) / DIGIT_W;
   localparam int ACC_W            = 3 * COORD_WIDTH + 8;
   localparam int QUEUE_DEPTH      = 2;
   localparam int CSR_IDX_W        = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DIST = 3'd6;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_TRI_LAST  = 5'd23;
   localparam logic [STEP_W-1:0] STEP_PNT_FIRST = 5'd24;
   localparam logic [STEP_W-1:0] STEP_PNT_LAST  = 5'd26;

   // operand A sources
   localparam logic [3:0] A_E1_0 = 4'd0;
   localparam logic [3:0] A_E1_1 = 4'd1;
   localparam logic [3:0] A_E1_2 = 4'd2;
   localparam logic [3:0] A_E2_0 = 4'd3;
   localparam logic [3:0] A_E2_1 = 4'd4;
   localparam logic [3:0] A_E2_2 = 4'd5;
   localparam logic [3:0] A_P_0  = 4'd6;
   localparam logic [3:0] A_P_1  = 4'd7;
   localparam logic [3:0] A_P_2  = 4'd8;
   localparam logic [3:0] A_Q_0  = 4'd9;
   localparam logic [3:0] A_Q_1  = 4'd10;
   localparam logic [3:0] A_Q_2  = 4'd11;
   localparam logic [3:0] A_DIR_0 = 4'd12;
   localparam logic [3:0] A_DIR_1 = 4'd13;
   localparam logic [3:0] A_DIR_2 = 4'd14;

   // operand B sources
   localparam logic [3:0] B_D_0  = 4'd0;
   localparam logic [3:0] B_D_1  = 4'd1;
   localparam logic [3:0] B_D_2  = 4'd2;
   localparam logic [3:0] B_E1_0 = 4'd3;
   localparam logic [3:0] B_E1_1 = 4'd4;
   localparam logic [3:0] B_E1_2 = 4'd5;
   localparam logic [3:0] B_TV_0 = 4'd6;
   localparam logic [3:0] B_TV_1 = 4'd7;
   localparam logic [3:0] B_TV_2 = 4'd8;
   localparam logic [3:0] B_E2_0 = 4'd9;
   localparam logic [3:0] B_E2_1 = 4'd10;
   localparam logic [3:0] B_E2_2 = 4'd11;
   localparam logic [3:0] B_T    = 4'd12;

   // accumulator destinations
   localparam logic [3:0] D_P0   = 4'd0;
   localparam logic [3:0] D_P1   = 4'd1;
   localparam logic [3:0] D_P2   = 4'd2;
   localparam logic [3:0] D_Q0   = 4'd3;
   localparam logic [3:0] D_Q1   = 4'd4;
   localparam logic [3:0] D_Q2   = 4'd5;
   localparam logic [3:0] D_DET  = 4'd6;
   localparam logic [3:0] D_UN   = 4'd7;
   localparam logic [3:0] D_VN   = 4'd8;
   localparam logic [3:0] D_TN   = 4'd9;
   localparam logic [3:0] D_PT0  = 4'd10;
   localparam logic [3:0] D_PT1  = 4'd11;
   localparam logic [3:0] D_PT2  = 4'd12;
   localparam logic [3:0] D_NONE = 4'd15;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] a_x;
      logic [COORD_WIDTH-1:0] a_y;
      logic [COORD_WIDTH-1:0] a_z;
      logic [COORD_WIDTH-1:0] b_x;
      logic [COORD_WIDTH-1:0] b_y;
      logic [COORD_WIDTH-1:0] b_z;
      logic [COORD_WIDTH-1:0] c_x;
      logic [COORD_WIDTH-1:0] c_y;
      logic [COORD_WIDTH-1:0] c_z;
      logic                   last_triangle;
   } req_type;

   typedef struct packed {
      logic                   hit_found;
      logic [COORD_WIDTH-2:0] hit_distance;
      logic [COORD_WIDTH-1:0] point_x;
      logic [COORD_WIDTH-1:0] point_y;
      logic [COORD_WIDTH-1:0] point_z;
   } rsp_type;

   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0] origin;
      logic [2:0][COORD_WIDTH-1:0] dir;
      logic [COORD_WIDTH-2:0]      min_dist;
   } ray_type;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] e1;
      logic [2:0][DIFF_W-1:0] e2;
      logic [2:0][DIFF_W-1:0] tv;
      logic                   last;
   } tri_type;

   typedef struct packed {
      logic [3:0] asel;
      logic [3:0] bsel;
      logic       sub;
      logic       last;
      logic [3:0] dst;
   } mac_op_type;

   function automatic mac_op_type mk_op(input logic [3:0] asel, input logic [3:0] bsel,
                                        input logic sub, input logic last,
                                        input logic [3:0] dst);
      mac_op_type o;
      o.asel = asel;
      o.bsel = bsel;
      o.sub  = sub;
      o.last = last;
      o.dst  = dst;
      return o;
   endfunction

   // p = d x e2, det = e1.p, q = tv x e1, u = tv.p, v = d.q, t = e2.q, point = dir * t
   function automatic mac_op_type mac_op(input logic [STEP_W-1:0] step);
      mac_op_type o;
      case (step)
         5'd0:  o = mk_op(A_E2_2, B_D_1, 1'b0, 1'b0, D_NONE);
         5'd1:  o = mk_op(A_E2_1, B_D_2, 1'b1, 1'b1, D_P0);
         5'd2:  o = mk_op(A_E2_0, B_D_2, 1'b0, 1'b0, D_NONE);
         5'd3:  o = mk_op(A_E2_2, B_D_0, 1'b1, 1'b1, D_P1);
         5'd4:  o = mk_op(A_E2_1, B_D_0, 1'b0, 1'b0, D_NONE);
         5'd5:  o = mk_op(A_E2_0, B_D_1, 1'b1, 1'b1, D_P2);
         5'd6:  o = mk_op(A_P_0, B_E1_0, 1'b0, 1'b0, D_NONE);
         5'd7:  o = mk_op(A_P_1, B_E1_1, 1'b0, 1'b0, D_NONE);
         5'd8:  o = mk_op(A_P_2, B_E1_2, 1'b0, 1'b1, D_DET);
         5'd9:  o = mk_op(A_E1_2, B_TV_1, 1'b0, 1'b0, D_NONE);
         5'd10: o = mk_op(A_E1_1, B_TV_2, 1'b1, 1'b1, D_Q0);
         5'd11: o = mk_op(A_E1_0, B_TV_2, 1'b0, 1'b0, D_NONE);
         5'd12: o = mk_op(A_E1_2, B_TV_0, 1'b1, 1'b1, D_Q1);
         5'd13: o = mk_op(A_E1_1, B_TV_0, 1'b0, 1'b0, D_NONE);
         5'd14: o = mk_op(A_E1_0, B_TV_1, 1'b1, 1'b1, D_Q2);
         5'd15: o = mk_op(A_P_0, B_TV_0, 1'b0, 1'b0, D_NONE);
         5'd16: o = mk_op(A_P_1, B_TV_1, 1'b0, 1'b0, D_NONE);
         5'd17: o = mk_op(A_P_2, B_TV_2, 1'b0, 1'b1, D_UN);
         5'd18: o = mk_op(A_Q_0, B_D_0, 1'b0, 1'b0, D_NONE);
         5'd19: o = mk_op(A_Q_1, B_D_1, 1'b0, 1'b0, D_NONE);
         5'd20: o = mk_op(A_Q_2, B_D_2, 1'b0, 1'b1, D_VN);
         5'd21: o = mk_op(A_Q_0, B_E2_0, 1'b0, 1'b0, D_NONE);
         5'd22: o = mk_op(A_Q_1, B_E2_1, 1'b0, 1'b0, D_NONE);
         5'd23: o = mk_op(A_Q_2, B_E2_2, 1'b0, 1'b1, D_TN);
         5'd24: o = mk_op(A_DIR_0, B_T, 1'b0, 1'b1, D_PT0);
         5'd25: o = mk_op(A_DIR_1, B_T, 1'b0, 1'b1, D_PT1);
         5'd26: o = mk_op(A_DIR_2, B_T, 1'b0, 1'b1, D_PT2);
         default: o = mk_op(A_E1_0, B_D_0, 1'b0, 1'b0, D_NONE);
      endcase
      return o;
   endfunction

endpackage

[rtl/rtn_front.sv]
// Front end: takes triangles, forms edge and origin vectors, queues them for the back end.
module rtn_front import rtn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  ray_type ray,
   output logic    head_valid,
   output tri_type head,
   input  logic    pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tri_type            slot_ff [QUEUE_DEPTH];
   tri_type            entry;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic [2:0][COORD_WIDTH-1:0] va, vb, vc;

   assign va = {req_data.a_z, req_data.a_y, req_data.a_x};
   assign vb = {req_data.b_z, req_data.b_y, req_data.b_x};
   assign vc = {req_data.c_z, req_data.c_y, req_data.c_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         entry.e1[i] = DIFF_W'($signed(vb[i])) - DIFF_W'($signed(va[i]));
         entry.e2[i] = DIFF_W'($signed(vc[i])) - DIFF_W'($signed(va[i]));
         entry.tv[i] = DIFF_W'($signed(ray.origin[i])) - DIFF_W'($signed(va[i]));
      end
      entry.last = req_data.last_triangle;
   end

   assign req_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

[rtl/rtn_back.sv]
// Back end: shared multiply-accumulate, serial divider, nearest-hit tracking and result register.
module rtn_back import rtn_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  ray_type ray,
   input  logic    head_valid,
   input  tri_type head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NUM_W     = ACC_W + FRAC_BITS;
   localparam int CNT_W     = $clog2(NUM_W);
   localparam int DIG_IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int B_EXT_W   = NDIG * DIGIT_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAC  = 3'd1;
   localparam logic [2:0] ST_CHK  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_UPD  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [DIG_IDX_W-1:0]   dig_ff, dig_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [COORD_WIDTH-1:0] best_ff, best_in;
   logic                   any_ff, any_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [OPA_W-1:0] p_ff [3];
   logic signed [OPA_W-1:0] q_ff [3];
   logic signed [ACC_W-1:0] pt_ff [3];
   logic signed [ACC_W-1:0] det_ff, un_ff, vn_ff, tn_ff;
   logic [ACC_W-1:0]        den_ff, rem_ff, rem_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   rsp_type                 rsp_ff;

   mac_op_type              op;
   logic signed [OPA_W-1:0] a_op;
   logic signed [OPB_W-1:0] b_op;
   logic signed [B_EXT_W-1:0] b_ext;
   logic [DIGIT_W-1:0]      digit;
   logic signed [DIGIT_W:0] dig9;
   logic signed [OPA_W+DIGIT_W:0] prod;
   logic signed [ACC_W-1:0] sh, acc_nxt;
   logic                    dig_end, store;

   logic [ACC_W-1:0]        det_a, un_a, vn_a, tn_a;
   logic [ACC_W:0]          uv_sum, rs, rs_diff;
   logic                    det_neg, cand, ge;
   logic [COORD_WIDTH-1:0]  t_sat;
   logic                    upd, out_free;
   logic signed [ACC_W-1:0] pv [3];
   logic [2:0][COORD_WIDTH-1:0] psat;
   rsp_type                 rsp_load;

   // multiply-accumulate datapath: one digit of B per cycle, the top digit signed
   always_comb begin
      op = mac_op(step_ff);
      case (op.asel)
         A_E1_0:  a_op = OPA_W'($signed(head.e1[0]));
         A_E1_1:  a_op = OPA_W'($signed(head.e1[1]));
         A_E1_2:  a_op = OPA_W'($signed(head.e1[2]));
         A_E2_0:  a_op = OPA_W'($signed(head.e2[0]));
         A_E2_1:  a_op = OPA_W'($signed(head.e2[1]));
         A_E2_2:  a_op = OPA_W'($signed(head.e2[2]));
         A_P_0:   a_op = p_ff[0];
         A_P_1:   a_op = p_ff[1];
         A_P_2:   a_op = p_ff[2];
         A_Q_0:   a_op = q_ff[0];
         A_Q_1:   a_op = q_ff[1];
         A_Q_2:   a_op = q_ff[2];
         A_DIR_0: a_op = OPA_W'($signed(ray.dir[0]));
         A_DIR_1: a_op = OPA_W'($signed(ray.dir[1]));
         A_DIR_2: a_op = OPA_W'($signed(ray.dir[2]));
         default: a_op = '0;
      endcase
      case (op.bsel)
         B_D_0:   b_op = OPB_W'($signed(ray.dir[0]));
         B_D_1:   b_op = OPB_W'($signed(ray.dir[1]));
         B_D_2:   b_op = OPB_W'($signed(ray.dir[2]));
         B_E1_0:  b_op = OPB_W'($signed(head.e1[0]));
         B_E1_1:  b_op = OPB_W'($signed(head.e1[1]));
         B_E1_2:  b_op = OPB_W'($signed(head.e1[2]));
         B_TV_0:  b_op = OPB_W'($signed(head.tv[0]));
         B_TV_1:  b_op = OPB_W'($signed(head.tv[1]));
         B_TV_2:  b_op = OPB_W'($signed(head.tv[2]));
         B_E2_0:  b_op = OPB_W'($signed(head.e2[0]));
         B_E2_1:  b_op = OPB_W'($signed(head.e2[1]));
         B_E2_2:  b_op = OPB_W'($signed(head.e2[2]));
         B_T:     b_op = OPB_W'({1'b0, best_ff});
         default: b_op = '0;
      endcase
      b_ext   = B_EXT_W'(b_op);
      digit   = b_ext[dig_ff * DIGIT_W +: DIGIT_W];
      dig_end = (dig_ff == DIG_IDX_W'(NDIG - 1));
      dig9    = dig_end ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
      prod    = a_op * dig9;
      sh      = ACC_W'(prod) << (DIGIT_W * dig_ff);
      acc_nxt = op.sub ? acc_ff - sh : acc_ff + sh;
      store   = (state_ff == ST_MAC) && dig_end && op.last;
   end

   // hit test on the accumulated numerators
   always_comb begin
      det_neg = det_ff[ACC_W-1];
      det_a   = det_neg ? ACC_W'(-det_ff) : ACC_W'(det_ff);
      un_a    = det_neg ? ACC_W'(-un_ff)  : ACC_W'(un_ff);
      vn_a    = det_neg ? ACC_W'(-vn_ff)  : ACC_W'(vn_ff);
      tn_a    = det_neg ? ACC_W'(-tn_ff)  : ACC_W'(tn_ff);
      uv_sum  = {1'b0, un_a} + {1'b0, vn_a};
      cand    = (det_ff != '0) && !un_a[ACC_W-1] && !vn_a[ACC_W-1] &&
                (uv_sum <= {1'b0, det_a}) && !tn_a[ACC_W-1] && (tn_a != '0);
   end

   // restoring division, one quotient bit per cycle
   always_comb begin
      rs      = {rem_ff, num_ff[NUM_W-1]};
      rs_diff = rs - {1'b0, den_ff};
      ge      = (rs >= {1'b0, den_ff});
      rem_in  = ge ? rs_diff[ACC_W-1:0] : rs[ACC_W-1:0];
      num_in  = {num_ff[NUM_W-2:0], ge};
      t_sat   = (|num_ff[NUM_W-1:COORD_WIDTH]) ? '1 : num_ff[COORD_WIDTH-1:0];
      upd     = (t_sat > {1'b0, ray.min_dist}) && (!any_ff || (t_sat < best_ff));
   end

   // hit point, saturated
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pv[i] = (pt_ff[i] >>> FRAC_BITS) + ACC_W'($signed(ray.origin[i]));
         if (pv[i][ACC_W-1:COORD_WIDTH-1] != {(ACC_W - COORD_WIDTH + 1){pv[i][COORD_WIDTH-1]}})
         begin
            psat[i] = pv[i][ACC_W-1] ? {1'b1, {(COORD_WIDTH - 1){1'b0}}}
                                     : {1'b0, {(COORD_WIDTH - 1){1'b1}}};
         end else begin
            psat[i] = pv[i][COORD_WIDTH-1:0];
         end
      end
      rsp_load = '0;
      if (any_ff) begin
         rsp_load.hit_found    = 1'b1;
         rsp_load.hit_distance = best_ff[COORD_WIDTH-1] ? '1 : best_ff[COORD_WIDTH-2:0];
         rsp_load.point_x      = psat[0];
         rsp_load.point_y      = psat[1];
         rsp_load.point_z      = psat[2];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = ((state_ff == ST_FIN) && !head.last) || ((state_ff == ST_OUT) && out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      dig_in       = dig_ff;
      cnt_in       = cnt_ff;
      best_in      = best_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               step_in  = '0;
               dig_in   = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (dig_end) begin
               dig_in  = '0;
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_TRI_LAST) begin
                  state_in = ST_CHK;
               end else if (step_ff == STEP_PNT_LAST) begin
                  state_in = ST_OUT;
               end
            end else begin
               dig_in = dig_ff + 1'b1;
            end
         end
         ST_CHK: begin
            cnt_in   = '0;
            state_in = cand ? ST_DIV : ST_FIN;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (upd) begin
               best_in = t_sat;
               any_in  = 1'b1;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (head.last) begin
               step_in  = STEP_PNT_FIRST;
               dig_in   = '0;
               state_in = ST_MAC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               best_in      = '1;
               any_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (state_ff == ST_MAC) begin
         acc_in = (dig_end && op.last) ? '0 : acc_nxt;
      end else if (state_ff != ST_DIV) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         dig_ff       <= '0;
         cnt_ff       <= '0;
         best_ff      <= '1;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         dig_ff       <= dig_in;
         cnt_ff       <= cnt_in;
         best_ff      <= best_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (store) begin
         case (op.dst)
            D_P0:    p_ff[0]  <= OPA_W'(acc_nxt);
            D_P1:    p_ff[1]  <= OPA_W'(acc_nxt);
            D_P2:    p_ff[2]  <= OPA_W'(acc_nxt);
            D_Q0:    q_ff[0]  <= OPA_W'(acc_nxt);
            D_Q1:    q_ff[1]  <= OPA_W'(acc_nxt);
            D_Q2:    q_ff[2]  <= OPA_W'(acc_nxt);
            D_DET:   det_ff   <= acc_nxt;
            D_UN:    un_ff    <= acc_nxt;
            D_VN:    vn_ff    <= acc_nxt;
            D_TN:    tn_ff    <= acc_nxt;
            D_PT0:   pt_ff[0] <= acc_nxt;
            D_PT1:   pt_ff[1] <= acc_nxt;
            D_PT2:   pt_ff[2] <= acc_nxt;
            default: begin
            end
         endcase
      end
      if (state_ff == ST_CHK) begin
         den_ff <= det_a;
         rem_ff <= '0;
         num_ff <= NUM_W'(tn_a) << FRAC_BITS;
      end else if (state_ff == ST_DIV) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_ff <= rsp_load;
      end
   end

endmodule

[rtl/ray_triangle_nearest_hit.sv]
// Each triangle runs 24 products through one 68x9-bit multiply-accumulate at one digit per cycle;
// a triangle that passes the hit test then goes through a restoring divider at one quotient bit
// per cycle. The last triangle of a mesh adds three more products for the point.
// A two-entry queue takes new triangles while the back end is still busy with earlier ones.
// Synchronous reset sets origin 0, direction (0, 0, 1.0), min distance 0, empties the queue
// and clears the kept hit.
module ray_triangle_nearest_hit import rtn_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COORD_WIDTH-1:0] csr_wdata
);

   localparam ray_type RAY_RESET = '{
      origin:   '0,
      dir:      {COORD_WIDTH'(1) << FRAC_BITS, {(2 * COORD_WIDTH){1'b0}}},
      min_dist: '0
   };

   ray_type ray_ff, ray_in;
   tri_type head;
   logic    head_valid, pop;

   always_comb begin
      ray_in = ray_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_X: ray_in.origin[0] = csr_wdata;
            REG_ORIGIN_Y: ray_in.origin[1] = csr_wdata;
            REG_ORIGIN_Z: ray_in.origin[2] = csr_wdata;
            REG_DIR_X:    ray_in.dir[0]    = csr_wdata;
            REG_DIR_Y:    ray_in.dir[1]    = csr_wdata;
            REG_DIR_Z:    ray_in.dir[2]    = csr_wdata;
            REG_MIN_DIST: ray_in.min_dist  = csr_wdata[COORD_WIDTH-2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff <= RAY_RESET;
      end else begin
         ray_ff <= ray_in;
      end
   end

   rtn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .ray        (ray_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   rtn_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .ray        (ray_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/rtn_checker.sv]
// Port-level checks for the ray/triangle nearest-hit block, bound to the top level.
`include "ray_triangle_nearest_hit_assert.svh"

module rtn_checker import rtn_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input req_type                req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_type                rsp_data
);

   // meshes closed on the input side and not yet answered
   logic [2:0] pending_ff, pending_in;
   logic       last_in, rsp_xfer;

   assign last_in  = req_valid && req_ready && req_data.last_triangle;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (last_in && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_xfer && !last_in) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `RTN_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `RTN_ASSERT_IMPLY(a_miss_zero, rsp_valid && !rsp_data.hit_found, rsp_data.hit_distance == '0 && rsp_data.point_x == '0 && rsp_data.point_y == '0 && rsp_data.point_z == '0)
   `RTN_ASSERT_IMPLY(a_rsp_owed, rsp_valid, pending_ff != '0)
   `RTN_ASSERT_IMPLY(a_pending_bound, 1'b1, pending_ff <= 3'd4)

endmodule

bind ray_triangle_nearest_hit rtn_checker u_rtn_checker (.*);

[bench/rtn_hit_checker.sv]
// Checker for the nearest-hit block: tracks the ray registers, predicts results, compares them.
module rtn_hit_checker import rtn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COORD_WIDTH-1:0] csr_wdata,
   output int                     errors,
   output int                     pending
);
   typedef logic signed [191:0] wint;

   logic [COORD_WIDTH-1:0] ray_org [3];
   logic [COORD_WIDTH-1:0] ray_dir [3];
   logic [COORD_WIDTH-2:0] near_limit;
   logic [COORD_WIDTH-1:0] best_t;
   logic                   have_hit;
   rsp_type                hit_queue [$];

   assign pending = hit_queue.size();

   function automatic wint sx(input logic [COORD_WIDTH-1:0] v);
      return wint'($signed(v));
   endfunction

   task automatic trace_triangle(input req_type r);
      wint a[3], b[3], c[3], e1[3], e2[3], tv[3], d[3], p[3], q[3];
      wint det, un, vn, tn, t, lim, bt, hi, lo, pt;
      rsp_type x;
      a[0] = sx(r.a_x); a[1] = sx(r.a_y); a[2] = sx(r.a_z);
      b[0] = sx(r.b_x); b[1] = sx(r.b_y); b[2] = sx(r.b_z);
      c[0] = sx(r.c_x); c[1] = sx(r.c_y); c[2] = sx(r.c_z);
      for (int i = 0; i < 3; i++) begin
         d[i]  = sx(ray_dir[i]);
         e1[i] = b[i] - a[i];
         e2[i] = c[i] - a[i];
         tv[i] = sx(ray_org[i]) - a[i];
      end
      p[0] = d[1] * e2[2] - d[2] * e2[1];
      p[1] = d[2] * e2[0] - d[0] * e2[2];
      p[2] = d[0] * e2[1] - d[1] * e2[0];
      q[0] = tv[1] * e1[2] - tv[2] * e1[1];
      q[1] = tv[2] * e1[0] - tv[0] * e1[2];
      q[2] = tv[0] * e1[1] - tv[1] * e1[0];
      det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
      un  = tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2];
      vn  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
      tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
      if (det != 0) begin
         if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
         end
         if (un >= 0 && vn >= 0 && un + vn <= det && tn > 0) begin
            t = (tn <<< FRAC_BITS_DEF) / det;
            lim = 0;
            lim[COORD_WIDTH-1:0] = '1;
            if (t > lim) t = lim;
            lim = 0;
            lim[COORD_WIDTH-2:0] = near_limit;
            bt = 0;
            bt[COORD_WIDTH-1:0] = best_t;
            if (t > lim && (!have_hit || t < bt)) begin
               best_t   = t[COORD_WIDTH-1:0];
               have_hit = 1'b1;
            end
         end
      end
      if (r.last_triangle) begin
         x = '0;
         if (have_hit) begin
            x.hit_found    = 1'b1;
            x.hit_distance = best_t[COORD_WIDTH-1] ? '1 : best_t[COORD_WIDTH-2:0];
            bt = 0;
            bt[COORD_WIDTH-1:0] = best_t;
            hi = 0;
            hi[COORD_WIDTH-2:0] = '1;
            lo = -hi - 1;
            for (int i = 0; i < 3; i++) begin
               pt = ((d[i] * bt) >>> FRAC_BITS_DEF) + sx(ray_org[i]);
               if (pt > hi) pt = hi;
               if (pt < lo) pt = lo;
               case (i)
                  0: x.point_x = pt[COORD_WIDTH-1:0];
                  1: x.point_y = pt[COORD_WIDTH-1:0];
                  default: x.point_z = pt[COORD_WIDTH-1:0];
               endcase
            end
         end
         hit_queue = {hit_queue, x};
         best_t   = '1;
         have_hit = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ray_org[i] = '0;
            ray_dir[i] = '0;
         end
         ray_dir[2] = 1 << FRAC_BITS_DEF;
         near_limit = '0;
         best_t     = '1;
         have_hit   = 1'b0;
         hit_queue.delete();
         errors     = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ORIGIN_X: ray_org[0] = csr_wdata;
               REG_ORIGIN_Y: ray_org[1] = csr_wdata;
               REG_ORIGIN_Z: ray_org[2] = csr_wdata;
               REG_DIR_X:    ray_dir[0] = csr_wdata;
               REG_DIR_Y:    ray_dir[1] = csr_wdata;
               REG_DIR_Z:    ray_dir[2] = csr_wdata;
               REG_MIN_DIST: near_limit = csr_wdata[COORD_WIDTH-2:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) trace_triangle(req_data);
         if (rsp_valid && rsp_ready) begin
            if (hit_queue.size() == 0) begin
               $display("%0t unexpected result transfer: got %p", $time, rsp_data);
               errors++;
            end else begin
               want = hit_queue.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t result mismatch: exp found=%0d dist=%h pt=%h,%h,%h",
                           $time, want.hit_found, want.hit_distance,
                           want.point_x, want.point_y, want.point_z);
                  $display("%0t                  got found=%0d dist=%h pt=%h,%h,%h",
                           $time, rsp_data.hit_found, rsp_data.hit_distance,
                           rsp_data.point_x, rsp_data.point_y, rsp_data.point_z);
                  errors++;
               end
            end
         end
      end
   end
endmodule

[bench/ray_triangle_nearest_hit_tb.sv]
// Testbench top for the nearest-hit block: clock, reset, triangle and ray stimulus, verdict.
module ray_triangle_nearest_hit_tb;
   import rtn_pkg::*;

   localparam int ONE = 1 << FRAC_BITS_DEF;
   localparam int MAXI = 32'h7fffffff;
   localparam int MINI = 32'h80000000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int SETTLE = 400;
   localparam longint CYCLE_LIMIT = 3000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [COORD_WIDTH-1:0] csr_wdata = '0;
   int                     errors;
   int                     pending;
   bit                     quiet = 1'b0;
   longint                 cycles = 0;
   int                     org [3];
   int                     dir [3];

   ray_triangle_nearest_hit dut (.*);

   rtn_hit_checker hit_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_triangle(input req_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_ray(input int ox, oy, oz, dx, dy, dz, input int mn);
      int v [7];
      v = '{ox, oy, oz, dx, dy, dz, mn};
      org = '{ox, oy, oz};
      dir = '{dx, dy, dz};
      drain();
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= v[i];
         @(posedge clock);
      end
      csr_we    <= 1'b1;
      csr_index <= REG_UNUSED;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                        input bit last);
      req_type r;
      r = '{ax, ay, az, bx, by, bz, cx, cy, cz, last};
      return r;
   endfunction

   function automatic req_type noise_tri(input bit last);
      return make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, last);
   endfunction

   // triangle whose centroid lies on the ray at distance s (Q16.16)
   function automatic req_type aimed_tri(input int s, input bit last);
      int p [3], u [3], w [3];
      req_type r;
      for (int i = 0; i < 3; i++) begin
         p[i] = org[i] + int'((longint'(dir[i]) * s) >>> FRAC_BITS_DEF);
         u[i] = $urandom_range(0, 2 << 20) - (1 << 20);
         w[i] = $urandom_range(0, 2 << 20) - (1 << 20);
      end
      if ($urandom_range(0, 1))
         r = make_tri(p[0] + u[0], p[1] + u[1], p[2] + u[2], p[0] + w[0], p[1] + w[1],
                      p[2] + w[2], p[0] - u[0] - w[0], p[1] - u[1] - w[1],
                      p[2] - u[2] - w[2], last);
      else
         r = make_tri(p[0] + u[0], p[1] + u[1], p[2] + u[2], p[0] - u[0] - w[0],
                      p[1] - u[1] - w[1], p[2] - u[2] - w[2], p[0] + w[0], p[1] + w[1],
                      p[2] + w[2], last);
      return r;
   endfunction

   function automatic int rnd_small(input int lim);
      return $urandom_range(0, 2 * lim) - lim;
   endfunction

   initial begin
      int left;
      bit wild;
      req_type r;
      org = '{0, 0, 0};
      dir = '{0, 0, ONE};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset ray: along +z from the origin
      send_triangle(make_tri(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, 1));
      send_triangle(make_tri(-ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, ONE, -ONE, 5*ONE, 1));
      send_triangle(make_tri(-ONE, -ONE, 5*ONE, -ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, 1));
      send_triangle(make_tri(-ONE, -ONE, -5*ONE, ONE, -ONE, -5*ONE, 0, ONE, -5*ONE, 1));
      send_triangle(make_tri(0, 0, 4*ONE, ONE, 0, 4*ONE, 0, ONE, 4*ONE, 1));
      send_triangle(make_tri(-ONE, -ONE, 7*ONE, ONE, -ONE, 7*ONE, 0, ONE, 7*ONE, 0));
      send_triangle(make_tri(-ONE, -ONE, 3*ONE, ONE, -ONE, 3*ONE, 0, ONE, 3*ONE, 0));
      send_triangle(make_tri(-2*ONE, -ONE, 3*ONE, ONE, -ONE, 3*ONE, 0, 2*ONE, 3*ONE, 0));
      send_triangle(make_tri(MINI, MINI, MINI, MINI, MINI, MINI, MINI, MINI, MINI, 0));
      send_triangle(make_tri(MAXI, MAXI, MAXI, MINI, 0, MAXI, 0, MINI, -1, 1));
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send_triangle(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1));

      // hit exactly at the minimum distance does not count
      write_ray(0, 0, 0, 0, 0, ONE, 5*ONE);
      send_triangle(make_tri(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, 1));
      send_triangle(make_tri(-ONE, -ONE, 6*ONE, ONE, -ONE, 6*ONE, 0, ONE, 6*ONE, 1));

      // tiny direction: far hits clamp, clamped ties keep the first
      write_ray(0, 0, 0, 0, 0, 1, 0);
      send_triangle(make_tri(-ONE, -ONE, MAXI, ONE, -ONE, MAXI, 0, ONE, MAXI, 0));
      send_triangle(make_tri(-ONE, -ONE, MAXI - 5, ONE, -ONE, MAXI, 0, ONE, MAXI, 1));

      // point saturation at both ends
      write_ray(MAXI - ONE, MINI + ONE, 0, 16*ONE, -16*ONE, ONE, MAXI);
      send_triangle(aimed_tri(ONE, 1));
      write_ray(MAXI - ONE, MINI + ONE, 0, 16*ONE, -16*ONE, ONE, 0);
      send_triangle(make_tri(MAXI, MINI, 8*ONE, MAXI, MAXI, 8*ONE, MINI, 0, 8*ONE, 1));
      send_triangle(aimed_tri(ONE, 1));

      for (int ph = 0; ph < 12; ph++) begin
         wild = (ph % 4 == 3);
         if (ph == 11) quiet = 1'b1;
         if (wild)
            write_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      (ph == 3) ? MAXI : $urandom_range(0, 1 << 20));
         else
            write_ray(rnd_small(1 << 24), rnd_small(1 << 24), rnd_small(1 << 24),
                      rnd_small(1 << 20), rnd_small(1 << 20), rnd_small(1 << 20),
                      (ph % 4 == 0) ? 0 : $urandom_range(0, 8*ONE));
         left = 0;
         for (int n = 0; n < 100; n++) begin
            if (left == 0) left = $urandom_range(1, 8);
            left--;
            if (wild || $urandom_range(0, 6) == 0) r = noise_tri(left == 0);
            else r = aimed_tri($urandom_range(ONE / 4, 16 * ONE), left == 0);
            send_triangle(r);
         end
         if (left != 0) send_triangle(noise_tri(1'b1));
      end

      drain();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl
rtl/rtn_pkg.sv
rtl/rtn_front.sv
rtl/rtn_back.sv
rtl/ray_triangle_nearest_hit.sv
rtl/rtn_checker.sv
bench/rtn_hit_checker.sv
bench/ray_triangle_nearest_hit_tb.sv
